### sv/world_to_screen_projection_assert.svh
// Assertion macros for the world-to-screen projection block.
// Used by sv/world_to_screen_projection.sv; no other dependencies.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define W2S_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("w2s: assertion failed");
`define W2S_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("w2s: forbidden condition seen");
`else
`define W2S_ASSERT(lbl, clk, rst_n, prop)
`define W2S_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/w2s_pkg.sv
// Shared types, constants and helpers for the world-to-screen projection block.
// No dependencies; used by sv/world_to_screen_projection.sv.
`timescale 1ns / 1ps

package w2s_pkg;

	localparam int DATA_W  = 32;
	localparam int VP_W    = 16;
	localparam int MA_W    = 37;  // multiplier operand A: point coordinate or ndc
	localparam int MB_W    = 33;  // multiplier operand B: matrix entry or viewport side
	localparam int PROD_W  = MA_W + MB_W;
	localparam int NDC_W   = 37;
	localparam int Q_MAG_W = NDC_W - 1;

	localparam logic [VP_W-1:0] RESET_VP_W = 16'd1920;
	localparam logic [VP_W-1:0] RESET_VP_H = 16'd1080;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic REG_VP_WIDTH  = 1'b0;
	localparam logic REG_VP_HEIGHT = 1'b1;

	localparam logic [1:0] LAST_COL = 2'd2;
	localparam logic [1:0] BIAS_COL = 2'd3;
	localparam logic [1:0] LAST_ROW = 2'd2;
	localparam logic [1:0] W_ROW    = 2'd3;
	localparam logic       AXIS_X   = 1'b0;
	localparam logic       AXIS_Y   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_BIAS,
		S_CHECK,
		S_DIV,
		S_SCALE,
		S_FIN,
		S_DONE
	} state_t;

	// Clamp a wide signed value to 32 bits signed.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[PROD_W-1:DATA_W-1];
		all_zeros = ~|v[PROD_W-1:DATA_W-1];
		if (all_ones || all_zeros) begin
			return v[DATA_W-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

### sv/world_to_screen_projection.sv
// World-to-screen projection: matrix store, shared multiplier, serial divider, sequencer.
// Depends on sv/w2s_pkg.sv and sv/world_to_screen_projection_assert.svh.
//
// A load transaction (s_tuser = 0) writes one entry of the 4x4 row-major view matrix. A
// project transaction (s_tuser = 1) forms clip x, y and w with one shared multiplier (nine
// products plus a bias add per row), then divides clip x and clip y by w with a restoring
// divider that retires one quotient bit per cycle (32 + FRAC_BITS bits each), and scales
// both by the viewport on the same multiplier; values are Q16.16 at the default FRAC_BITS.
// The block is busy after accepting a point, skipping the divide and scale when w is below
// 0.1 or a viewport side is 1 or less, and takes the next point once its result has moved
// to the output register, where it sits, so loads are still accepted while it waits for
// m_tready. Viewport registers sit at byte addresses 0 (width) and 4 (height).
`timescale 1ns / 1ps
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [3:0] entry_index, [35:4] entry_value, [67:36] point_x, [99:68] point_y,
	// [131:100] point_z, [135:132] zero
	input  logic [135:0] s_tdata,
	// [0] operation
	input  logic         s_tuser,
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] screen_x, [63:32] screen_y
	output logic [63:0]  m_tdata,
	// [0] visible
	output logic         m_tuser,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int DIVW  = w2s_pkg::DATA_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIVW);
	localparam int W_MIN = ((1 << FRAC_BITS) + 9) / 10;
	localparam logic signed [w2s_pkg::DATA_W-1:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

	w2s_pkg::state_t state_q, state_d;

	logic [w2s_pkg::VP_W-1:0] vp_w_q, vp_h_q;
	logic signed [w2s_pkg::DATA_W-1:0] mat_q [16];
	logic signed [w2s_pkg::DATA_W-1:0] pt_q [3];
	logic signed [w2s_pkg::DATA_W-1:0] clip_q [3];
	logic [1:0] row_q, col_q;
	logic signed [w2s_pkg::PROD_W-1:0] prod_q, acc_q;
	logic [w2s_pkg::DATA_W-1:0] rem_q, div_q;
	logic [DIVW-1:0] dvd_q;
	logic neg_q;
	logic ax_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [w2s_pkg::DATA_W-1:0] res_x_q, res_y_q;
	logic res_vis_q;
	logic signed [w2s_pkg::DATA_W-1:0] out_x_q, out_y_q;
	logic out_vis_q, m_valid_q;

	logic s_accept, out_load, cfg_write;
	logic [3:0] mat_idx;
	logic [1:0] mrow;
	logic signed [w2s_pkg::DATA_W-1:0] mat_sel;
	logic signed [w2s_pkg::MA_W-1:0] mul_a;
	logic signed [w2s_pkg::MB_W-1:0] mul_b;
	logic signed [w2s_pkg::PROD_W-1:0] mul_p;
	logic [w2s_pkg::DATA_W:0] trial;
	logic [w2s_pkg::Q_MAG_W-1:0] q_mag;
	logic signed [w2s_pkg::NDC_W-1:0] ndc;
	logic [w2s_pkg::VP_W-1:0] vp_sel;
	logic signed [w2s_pkg::PROD_W-1:0] vp_off, half_prod;
	logic bad_view, bad_w, div_last;
	logic signed [w2s_pkg::DATA_W-1:0] div_src;
	logic [w2s_pkg::DATA_W-1:0] div_mag;

	// ---------------- configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == w2s_pkg::REG_VP_HEIGHT) ? {16'd0, vp_h_q} : {16'd0, vp_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= w2s_pkg::RESET_VP_W;
			vp_h_q <= w2s_pkg::RESET_VP_H;
		end else if (cfg_write) begin
			if (paddr[2] == w2s_pkg::REG_VP_HEIGHT) begin
				vp_h_q <= pwdata[w2s_pkg::VP_W-1:0];
			end else begin
				vp_w_q <= pwdata[w2s_pkg::VP_W-1:0];
			end
		end
	end

	// ---------------- outputs and datapath selects
	always_comb begin
		s_tready = (state_q == w2s_pkg::S_IDLE);
		mrow     = (row_q == w2s_pkg::LAST_ROW) ? w2s_pkg::W_ROW : row_q;
		mat_idx  = {mrow, (state_q == w2s_pkg::S_BIAS) ? w2s_pkg::BIAS_COL : col_q};
		vp_sel   = (ax_q == w2s_pkg::AXIS_Y) ? vp_h_q : vp_w_q;
		if (state_q == w2s_pkg::S_SCALE) begin
			mul_a = ndc;
			mul_b = w2s_pkg::MB_W'($signed({1'b0, vp_sel}));
		end else begin
			mul_a = w2s_pkg::MA_W'(pt_q[col_q]);
			mul_b = w2s_pkg::MB_W'(mat_sel);
		end
	end

	assign s_accept  = s_tvalid && s_tready;
	assign out_load  = (state_q == w2s_pkg::S_DONE) && (!m_valid_q || m_tready);
	assign mat_sel   = mat_q[mat_idx];
	assign mul_p     = mul_a * mul_b;
	assign trial     = {rem_q, dvd_q[DIVW-1]} - {1'b0, div_q};
	assign q_mag     = dvd_q[w2s_pkg::Q_MAG_W-1:0];
	assign ndc       = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign vp_off    = $signed(w2s_pkg::PROD_W'(vp_sel)) <<< (FRAC_BITS - 1);
	assign half_prod = prod_q >>> 1;
	assign bad_view  = (vp_w_q[w2s_pkg::VP_W-1:1] == '0) || (vp_h_q[w2s_pkg::VP_W-1:1] == '0);
	assign bad_w     = clip_q[2] < $signed(w2s_pkg::DATA_W'(W_MIN));
	assign div_last  = (cnt_q == CNT_W'(DIVW - 1));
	// divider source: clip x from the check state, clip y after the x scale
	assign div_src   = (state_q == w2s_pkg::S_CHECK) ? clip_q[0] : clip_q[1];
	assign div_mag   = div_src[w2s_pkg::DATA_W-1] ? w2s_pkg::DATA_W'(-div_src) : div_src;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_vis_q;

	// ---------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			w2s_pkg::S_IDLE: begin
				if (s_accept && s_tuser == w2s_pkg::OP_PROJECT) begin
					state_d = w2s_pkg::S_MUL;
				end
			end
			w2s_pkg::S_MUL: state_d = w2s_pkg::S_ACC;
			w2s_pkg::S_ACC: begin
				state_d = (col_q == w2s_pkg::LAST_COL) ? w2s_pkg::S_BIAS : w2s_pkg::S_MUL;
			end
			w2s_pkg::S_BIAS: begin
				state_d = (row_q == w2s_pkg::LAST_ROW) ? w2s_pkg::S_CHECK : w2s_pkg::S_MUL;
			end
			w2s_pkg::S_CHECK: begin
				state_d = (bad_view || bad_w) ? w2s_pkg::S_DONE : w2s_pkg::S_DIV;
			end
			w2s_pkg::S_DIV: begin
				if (div_last) begin
					state_d = w2s_pkg::S_SCALE;
				end
			end
			w2s_pkg::S_SCALE: state_d = w2s_pkg::S_FIN;
			w2s_pkg::S_FIN: begin
				state_d = (ax_q == w2s_pkg::AXIS_Y) ? w2s_pkg::S_DONE : w2s_pkg::S_DIV;
			end
			w2s_pkg::S_DONE: begin
				if (out_load) begin
					state_d = w2s_pkg::S_IDLE;
				end
			end
			default: state_d = w2s_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= w2s_pkg::S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// matrix store, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= '0;
			end
		end else if (s_accept && s_tuser == w2s_pkg::OP_LOAD) begin
			mat_q[s_tdata[3:0]] <= s_tdata[35:4];
		end
	end

	// ---------------- datapath (no reset on payload)
	always_ff @(posedge clk) begin
		unique case (state_q)
			w2s_pkg::S_IDLE: begin
				if (s_accept) begin
					pt_q[0] <= s_tdata[67:36];
					pt_q[1] <= s_tdata[99:68];
					pt_q[2] <= s_tdata[131:100];
					row_q   <= '0;
					col_q   <= '0;
					acc_q   <= '0;
				end
			end
			w2s_pkg::S_MUL: prod_q <= mul_p;
			w2s_pkg::S_ACC: begin
				acc_q <= acc_q + (prod_q >>> FRAC_BITS);
				col_q <= (col_q == w2s_pkg::LAST_COL) ? 2'd0 : col_q + 2'd1;
			end
			w2s_pkg::S_BIAS: begin
				clip_q[row_q] <= w2s_pkg::sat32(acc_q + w2s_pkg::PROD_W'(mat_sel));
				acc_q         <= '0;
				row_q         <= row_q + 2'd1;
			end
			w2s_pkg::S_CHECK: begin
				res_x_q   <= NEG_ONE;
				res_y_q   <= NEG_ONE;
				res_vis_q <= !(bad_view || bad_w);
				// start x divide
				ax_q  <= w2s_pkg::AXIS_X;
				rem_q <= '0;
				div_q <= clip_q[2];
				dvd_q <= {div_mag, {FRAC_BITS{1'b0}}};
				neg_q <= div_src[w2s_pkg::DATA_W-1];
				cnt_q <= '0;
			end
			w2s_pkg::S_DIV: begin
				// one restoring step: shift in next dividend bit, subtract when it fits
				if (!trial[w2s_pkg::DATA_W]) begin
					rem_q <= trial[w2s_pkg::DATA_W-1:0];
				end else begin
					rem_q <= {rem_q[w2s_pkg::DATA_W-2:0], dvd_q[DIVW-1]};
				end
				dvd_q <= {dvd_q[DIVW-2:0], !trial[w2s_pkg::DATA_W]};
				cnt_q <= cnt_q + 1'b1;
			end
			w2s_pkg::S_SCALE: prod_q <= mul_p;
			w2s_pkg::S_FIN: begin
				if (ax_q == w2s_pkg::AXIS_X) begin
					res_x_q <= w2s_pkg::sat32(half_prod + vp_off);
					// start y divide
					ax_q  <= w2s_pkg::AXIS_Y;
					rem_q <= '0;
					dvd_q <= {div_mag, {FRAC_BITS{1'b0}}};
					neg_q <= div_src[w2s_pkg::DATA_W-1];
					cnt_q <= '0;
				end else begin
					res_y_q <= w2s_pkg::sat32(vp_off - half_prod);
				end
			end
			w2s_pkg::S_DONE: begin
				if (out_load) begin
					out_x_q   <= res_x_q;
					out_y_q   <= res_y_q;
					out_vis_q <= res_vis_q;
				end
			end
			default: ;
		endcase
	end

	// ---------------- assertions
	`W2S_NEVER(a_rem_below_divisor, clk, arst_n, (state_q == w2s_pkg::S_DIV) && (rem_q >= div_q))
	`W2S_ASSERT(a_divisor_min, clk, arst_n, (state_q == w2s_pkg::S_DIV) |-> (div_q >= 32'(W_MIN)))
	`W2S_ASSERT(a_hidden_is_neg_one, clk, arst_n, (m_valid_q && !out_vis_q) |-> (out_x_q == NEG_ONE && out_y_q == NEG_ONE))
	`W2S_ASSERT(a_busy_after_point, clk, arst_n, (s_accept && s_tuser == w2s_pkg::OP_PROJECT) |=> !s_tready)

endmodule

### test/world_to_screen_projection_checker.sv
// Checker for the world-to-screen projection block: watches the stream and APB channels,
// predicts each screen result and compares it field by field. Depends on sv/w2s_pkg.sv.
`timescale 1ns / 1ps

module world_to_screen_projection_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// [3:0] entry_index, [35:4] entry_value, [67:36] point_x, [99:68] point_y,
	// [131:100] point_z, [135:132] zero
	input  logic [135:0] s_tdata,
	// [0] operation
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] screen_x, [63:32] screen_y
	input  logic [63:0]  m_tdata,
	// [0] visible
	input  logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [31:0] sx;
		logic [31:0] sy;
		logic        vis;
	} screen_pt_t;

	localparam longint ONE     = longint'(1) << FRAC_BITS;
	localparam longint W_FLOOR = (ONE + 9) / 10;  // smallest clip w still in front
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -S32_MAX - 1;

	logic signed [31:0] view_mat [16];
	logic [15:0]        vp_width;
	logic [15:0]        vp_height;
	screen_pt_t         screen_q [$];
	int                 fail_cnt = 0;

	task automatic note_mismatch(input string what);
		$display("%0t ns checker: %s", $time, what);
		fail_cnt++;
	endtask

	function automatic longint clamp32(input longint v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end else if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	// Products floor-shifted one by one, then bias added and the sum clamped.
	function automatic longint clip_row(input int row, input longint px, py, pz);
		longint sum;
		sum = ((px * longint'(view_mat[4*row]))     >>> FRAC_BITS)
		    + ((py * longint'(view_mat[4*row + 1])) >>> FRAC_BITS)
		    + ((pz * longint'(view_mat[4*row + 2])) >>> FRAC_BITS)
		    + longint'(view_mat[4*row + 3]);
		return clamp32(sum);
	endfunction

	function automatic screen_pt_t project_point(input logic [31:0] x, y, z);
		longint     px, py, pz, cx, cy, cw, ndc_x, ndc_y, vw, vh;
		screen_pt_t res;
		px = longint'($signed(x));
		py = longint'($signed(y));
		pz = longint'($signed(z));
		// rows x, y and w of the view matrix
		cx = clip_row(0, px, py, pz);
		cy = clip_row(1, px, py, pz);
		cw = clip_row(3, px, py, pz);
		vw = longint'(vp_width);
		vh = longint'(vp_height);
		if (vw <= 1 || vh <= 1 || cw < W_FLOOR) begin
			res.sx  = 32'(-ONE);
			res.sy  = 32'(-ONE);
			res.vis = 1'b0;
		end else begin
			ndc_x   = (cx <<< FRAC_BITS) / cw;
			ndc_y   = (cy <<< FRAC_BITS) / cw;
			res.sx  = 32'(clamp32(((vw * ndc_x) >>> 1) + vw * (ONE / 2)));
			res.sy  = 32'(clamp32(vh * (ONE / 2) - ((vh * ndc_y) >>> 1)));
			res.vis = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_pt_t got;
		screen_pt_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) view_mat[i] = '0;
			vp_width  = w2s_pkg::RESET_VP_W;
			vp_height = w2s_pkg::RESET_VP_H;
			screen_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {w2s_pkg::REG_VP_WIDTH, 2'b00}) begin
					vp_width = pwdata[15:0];
				end else if (paddr == {w2s_pkg::REG_VP_HEIGHT, 2'b00}) begin
					vp_height = pwdata[15:0];
				end
			end
			// retire the output transaction before queuing a new point at this edge
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tuser};
				if (screen_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result x=%h y=%h visible=%b",
						got.sx, got.sy, got.vis));
				end else begin
					want = screen_q.pop_front();
					if (got.sx !== want.sx)
						note_mismatch($sformatf("screen_x %h, want %h", got.sx, want.sx));
					if (got.sy !== want.sy)
						note_mismatch($sformatf("screen_y %h, want %h", got.sy, want.sy));
					if (got.vis !== want.vis)
						note_mismatch($sformatf("visible %b, want %b", got.vis, want.vis));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == w2s_pkg::OP_LOAD) begin
					view_mat[s_tdata[3:0]] = s_tdata[35:4];
				end else begin
					screen_q.push_back(project_point(s_tdata[67:36], s_tdata[99:68],
						s_tdata[131:100]));
				end
			end
			pending <= screen_q.size();
		end
		errors <= fail_cnt;
	end

endmodule

### test/tb.sv
// Testbench top for the world-to-screen projection block: clock, reset, stream and APB
// stimulus, verdict. Depends on sv/w2s_pkg.sv and test/world_to_screen_projection_checker.sv.
`timescale 1ns / 1ps

module tb;

	localparam int          LIMIT = 500000;
	localparam int          DRAIN = 160;  // covers one full point at Q16.16
	localparam int unsigned ONE   = 65536;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata  = '0;
	logic         s_tuser  = w2s_pkg::OP_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int tx_idle = 0;
	int rx_idle = 0;
	int cycles  = 0;
	int errors;
	int pending;

	world_to_screen_projection u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	world_to_screen_projection_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[world_to_screen_projection] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] pick_extreme();
		unique case ($urandom_range(0, 4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0000_0001;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// mostly within +-4.0, sometimes extreme or fully random
	function automatic logic [31:0] rand_entry();
		unique case ($urandom_range(0, 9))
			0: return pick_extreme();
			1: return $urandom();
			default: return $urandom_range(0, 8 * ONE) - 4 * ONE;
		endcase
	endfunction

	// mostly within +-256.0, sometimes extreme or fully random
	function automatic logic [31:0] rand_coord();
		unique case ($urandom_range(0, 9))
			0: return pick_extreme();
			1: return $urandom();
			default: return $urandom_range(0, 512 * ONE) - 256 * ONE;
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [3:0] idx, input logic [31:0] val,
			input logic [31:0] px, py, pz);
		if ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, pz, py, px, val, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	// unused fields carry random bits
	task automatic load_entry(input logic [3:0] idx, input logic [31:0] val);
		send_item(w2s_pkg::OP_LOAD, idx, val, $urandom(), $urandom(), $urandom());
	endtask

	task automatic project(input logic [31:0] px, py, pz);
		send_item(w2s_pkg::OP_PROJECT, 4'($urandom_range(0, 15)), $urandom(), px, py, pz);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [15:0] value);
		logic [15:0] junk;
		junk = 16'($urandom());
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drop valid, wait for every result, then let a trailing point finish
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		logic [31:0] v;
		logic [15:0] vw;
		logic [15:0] vh;
		int          n_rand;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 8; phase++) begin
			tx_idle = (phase < 2) ? 24 : (phase < 4) ? 69 : 0;
			rx_idle = (phase < 2) ? 69 : (phase < 4) ? 24 : 0;
			n_rand  = (phase == 2 || phase == 4 || phase == 6) ? 16 : 48;
			vw = 16'd1920;
			vh = 16'd1080;
			unique case (phase)
				1: begin vw = 16'd65535; vh = 16'd65535; end
				2: begin vw = 16'd1;     vh = 16'd1080;  end
				3: begin
					vw = 16'($urandom_range(2, 4096));
					vh = 16'($urandom_range(2, 4096));
				end
				4: begin vw = 16'd65535; vh = 16'd1;     end
				5: begin vw = 16'd2;     vh = 16'd2;     end
				6: begin vw = 16'd0;     vh = 16'd0;     end
				7: begin
					vw = 16'($urandom_range(0, 65535));
					vh = 16'($urandom_range(0, 65535));
				end
				default: ;
			endcase
			if (phase > 0) begin
				settle();
				apb_write(w2s_pkg::REG_VP_WIDTH, vw);
				apb_write(w2s_pkg::REG_VP_HEIGHT, vh);
			end
			if (phase == 0) begin
				// w = z: identity in x and y, row three picks z
				load_entry(4'd0, ONE);
				load_entry(4'd5, ONE);
				load_entry(4'd14, ONE);
				project(32'd0, 32'd0, ONE);
				project(ONE / 2, -(ONE / 2), ONE);
				project(ONE, ONE, 32'd6554);      // w right at the visibility threshold
				project(ONE, ONE, 32'd6553);      // just below the visibility threshold
				project(32'd0, 32'd0, 32'd0);
				project(32'd0, 32'd0, 32'h8000_0000);
				project(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);
				project(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
				project(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				load_entry(4'd15, 32'h7FFF_FFFF);
				load_entry(4'd3, 32'h8000_0000);
				project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				load_entry(4'd12, 32'h8000_0000);
				project(ONE, 32'd0, 32'd0);
			end
			// fresh matrix with a mostly forward-facing w row
			for (int i = 0; i < 16; i++) begin
				unique case (i)
					12, 13: v = $urandom_range(0, ONE / 2) - ONE / 4;
					14: v = $urandom_range(ONE / 2, 2 * ONE);
					15: v = $urandom_range(0, 8 * ONE);
					default: v = rand_entry();
				endcase
				load_entry(4'(i), v);
			end
			for (int k = 0; k < n_rand; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					load_entry(4'($urandom_range(0, 15)), rand_entry());
				end else begin
					project(rand_coord(), rand_coord(),
						($urandom_range(0, 3) != 0) ? $urandom_range(ONE / 16, 300 * ONE)
						: rand_coord());
				end
			end
		end
		settle();
		if (errors == 0 && pending == 0) begin
			$display("[world_to_screen_projection] OK");
		end else begin
			$display("[world_to_screen_projection] ERROR");
		end
		$finish;
	end

endmodule
